>>> rtl/hps_pkg.sv
// ----------------------------------------------------------------------------
// hps_pkg
// Types, constants and the square-root step function of the hillshade shader.
// ----------------------------------------------------------------------------
`default_nettype none

package hps_pkg;

  localparam int ELEV_BITS   = 24;
  localparam int MAG_W       = 34;
  localparam int HALF_W      = MAG_W / 2;
  localparam int SQRT_STAGES = 4;
  localparam int SQRT_STEPS  = 16 / SQRT_STAGES;
  localparam int SQRT_W      = 34;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;
  localparam int PIPE_DEPTH  = 8 + 2 * SQRT_STAGES;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLOPE_GAIN = 2'd0,
    REG_SUN_SIN    = 2'd1,
    REG_SUN_COS    = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic signed [ELEV_BITS-1:0] elev_upper_left;
    logic signed [ELEV_BITS-1:0] elev_lower_right;
    logic [7:0]                  base_red;
    logic [7:0]                  base_green;
    logic [7:0]                  base_blue;
  } in_t;

  typedef struct packed {
    logic [7:0] shaded_red;
    logic [7:0] shaded_green;
    logic [7:0] shaded_blue;
  } out_t;

  typedef struct packed {
    logic [23:0]        slope_gain;
    logic signed [15:0] sun_sin;
    logic signed [15:0] sun_cos;
  } cfg_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } chan_k_t;

  typedef struct packed {
    logic [SQRT_W-1:0] v;
    logic [SQRT_W-1:0] r;
  } sqrt_st_t;

  // SQRT_STEPS digit steps of the restoring square root for pipeline stage stg
  function automatic sqrt_st_t sqrt_steps(sqrt_st_t st, int stg);
    sqrt_st_t          o;
    logic [SQRT_W-1:0] b;
    logic [SQRT_W-1:0] t;
    o = st;
    for (int i = 0; i < SQRT_STEPS; i++) begin
      b = SQRT_W'(1) << (2 * (15 - SQRT_STEPS * stg - i));
      t = o.r + b;
      if (o.v >= t) begin
        o.v = o.v - t;
        o.r = (o.r >> 1) + b;
      end else begin
        o.r = o.r >> 1;
      end
    end
    return o;
  endfunction

  function automatic logic [15:0] chan_k(logic [7:0] ch);
    return 16'd8192 + 16'(ch) * 16'd224;
  endfunction

  function automatic logic [7:0] chan_sat(logic [31:0] p);
    logic [8:0] v;
    v = p[31:23];
    return (v > 9'd255) ? 8'hff : v[7:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/hps_cfg_regs.sv
// ----------------------------------------------------------------------------
// hps_cfg_regs
// Configuration registers: slope gain and sun angle sine and cosine.
// ----------------------------------------------------------------------------
`default_nettype none

module hps_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            wr_en_i,
  input  wire logic [hps_pkg::CFG_IDX_W-1:0]   wr_index_i,
  input  wire logic [hps_pkg::CFG_DATA_W-1:0]  wr_data_i,
  output hps_pkg::cfg_t                        cfg_o
);

  hps_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slope_gain <= 24'd46478;
      cfg_q.sun_sin    <= 16'sd23170;
      cfg_q.sun_cos    <= 16'sd23170;
    end else if (wr_en_i) begin
      unique case (wr_index_i)
        hps_pkg::REG_SLOPE_GAIN: cfg_q.slope_gain <= wr_data_i;
        hps_pkg::REG_SUN_SIN:    cfg_q.sun_sin    <= wr_data_i[15:0];
        hps_pkg::REG_SUN_COS:    cfg_q.sun_cos    <= wr_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> rtl/hps_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// hps_sqrt_pipe
// Pipelined floor square root, 32-bit radicand, 16-bit root.
// ----------------------------------------------------------------------------
`default_nettype none

module hps_sqrt_pipe (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] value_i,
  output logic      [15:0] root_o
);

  hps_pkg::sqrt_st_t st_q [hps_pkg::SQRT_STAGES];
  hps_pkg::sqrt_st_t st_in;

  assign st_in.v = hps_pkg::SQRT_W'(value_i);
  assign st_in.r = '0;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= hps_pkg::sqrt_steps(st_in, 0);
      for (int k = 1; k < hps_pkg::SQRT_STAGES; k++) begin
        st_q[k] <= hps_pkg::sqrt_steps(st_q[k-1], k);
      end
    end
  end

  assign root_o = st_q[hps_pkg::SQRT_STAGES-1].r[15:0];

endmodule

`default_nettype wire

>>> rtl/hillshade_pixel_shader_top.sv
// ----------------------------------------------------------------------------
// hillshade_pixel_shader_top
// Per-pixel hillshade: slope from two diagonal elevations, relief term from
// the sun angle, square-root shade factor applied to the base color.
// ----------------------------------------------------------------------------
//  channel | signals                              | direction
//  in      | in_valid_i, in_stall_o, in_data_i    | request in
//  out     | out_valid_o, out_stall_i, out_data_o | request out
//  cfg     | cfg_valid_i, cfg_ready_o, index/data | register write
//
//  One request per cycle unless the output stalls; the pipeline depth includes
//  the stages of the two pipelined square-root units.
//  Reset restores the register defaults and clears all valid bits.
//  The whole pipeline holds while a finished result is stalled at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module hillshade_pixel_shader_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire hps_pkg::in_t                    in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output hps_pkg::out_t                        out_data_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [hps_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [hps_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  hps_pkg::cfg_t                   cfg;
  logic                            en;
  logic                            accept;
  logic [hps_pkg::PIPE_DEPTH:1]    v_q;

  assign cfg_ready_o = 1'b1;
  assign en          = !(v_q[hps_pkg::PIPE_DEPTH] && out_stall_i);
  assign in_stall_o  = !en;
  assign accept      = in_valid_i && en;
  assign out_valid_o = v_q[hps_pkg::PIPE_DEPTH];

  hps_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[hps_pkg::PIPE_DEPTH-1:1], in_valid_i};
    end
  end

  // stage 1: difference magnitude, channel coefficients
  logic signed [hps_pkg::ELEV_BITS+1:0] diff;
  logic [hps_pkg::MAG_W-1:0]            mag_q;
  logic                                 neg_q [2:3];
  hps_pkg::chan_k_t                     k_q [1:hps_pkg::PIPE_DEPTH-2];

  assign diff = (hps_pkg::ELEV_BITS+2)'(in_data_i.elev_upper_left)
              - (hps_pkg::ELEV_BITS+2)'(in_data_i.elev_lower_right);

  // stage 2: partial products of magnitude and gain
  logic [hps_pkg::HALF_W+23:0] plo_q, phi_q;
  // stage 3: saturated slope
  logic [57:0]          psum;
  logic [52:0]          q;
  logic [16:0]          qs;
  logic signed [16:0]   s_q;
  // stage 4: radicand
  logic signed [33:0]   sq;
  logic [31:0]          rad_q;
  logic signed [16:0]   sd_q [0:hps_pkg::SQRT_STAGES];
  // after first root
  logic [15:0]          root;
  logic signed [32:0]   pa_d, pb_d, pa_q, pb_q;
  logic signed [33:0]   c;
  logic [33:0]          cabs;
  logic [31:0]          absc_q;
  logic [15:0]          f;
  logic [31:0]          pr_q, pg_q, pbl_q;
  hps_pkg::out_t        out_q;

  assign psum = {phi_q, {hps_pkg::HALF_W{1'b0}}} + 58'(plo_q);
  assign q    = psum[57:5];
  assign qs   = (q > 53'd32768) ? 17'd32768 : q[16:0];
  assign sq   = s_q * s_q;
  assign pa_d = cfg.sun_sin * $signed({1'b0, root});
  assign pb_d = cfg.sun_cos * sd_q[hps_pkg::SQRT_STAGES];
  assign c    = 34'(pa_q) - 34'(pb_q);
  assign cabs = c[33] ? 34'(-c) : 34'(c);

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q    <= diff[hps_pkg::ELEV_BITS+1] ? hps_pkg::MAG_W'(-diff)
                                             : hps_pkg::MAG_W'(diff);
      neg_q[2] <= diff[hps_pkg::ELEV_BITS+1];
      k_q[1]   <= '{red:   hps_pkg::chan_k(in_data_i.base_red),
                    green: hps_pkg::chan_k(in_data_i.base_green),
                    blue:  hps_pkg::chan_k(in_data_i.base_blue)};
      for (int i = 2; i <= hps_pkg::PIPE_DEPTH - 2; i++) k_q[i] <= k_q[i-1];
      plo_q    <= mag_q[hps_pkg::HALF_W-1:0] * cfg.slope_gain;
      phi_q    <= mag_q[hps_pkg::MAG_W-1:hps_pkg::HALF_W] * cfg.slope_gain;
      neg_q[3] <= neg_q[2];
      s_q      <= neg_q[3] ? -$signed(qs) : $signed(qs);
      rad_q    <= 32'(34'sh40000000 - sq);
      sd_q[0]  <= s_q;
      for (int i = 1; i <= hps_pkg::SQRT_STAGES; i++) sd_q[i] <= sd_q[i-1];
      pa_q     <= pa_d;
      pb_q     <= pb_d;
      absc_q   <= cabs[31:0];
      pr_q     <= k_q[hps_pkg::PIPE_DEPTH-2].red   * f;
      pg_q     <= k_q[hps_pkg::PIPE_DEPTH-2].green * f;
      pbl_q    <= k_q[hps_pkg::PIPE_DEPTH-2].blue  * f;
      out_q    <= '{shaded_red:   hps_pkg::chan_sat(pr_q),
                    shaded_green: hps_pkg::chan_sat(pg_q),
                    shaded_blue:  hps_pkg::chan_sat(pbl_q)};
    end
  end

  hps_sqrt_pipe u_sqrt_root (
    .clk_i   (clk_i),
    .en_i    (en),
    .value_i (rad_q),
    .root_o  (root)
  );

  hps_sqrt_pipe u_sqrt_shade (
    .clk_i   (clk_i),
    .en_i    (en),
    .value_i (absc_q),
    .root_o  (f)
  );

  assign out_data_o = out_q;

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled without a waiting result");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> v_q[1])
    else $error("accepted request lost at entry");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> v_q == $past(v_q))
    else $error("pipeline moved while held");

endmodule

`default_nettype wire

>>> test/hillshade_pixel_shader_top_tb.sv
// ----------------------------------------------------------------------------
// hillshade_pixel_shader_top_tb
// Drives pixels and register writes into the hillshade shader, predicts each
// shaded color with an independent fixed-point model and checks every result
// in order, under several idle and stall patterns and register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module hillshade_pixel_shader_top_tb;

  class shade_board;
    logic [23:0]        gain;
    logic signed [15:0] sin_q;
    logic signed [15:0] cos_q;
    hps_pkg::out_t      pending[$];
    int                 errors;

    function new();
      gain = 24'd46478;
      sin_q = 16'sd23170;
      cos_q = 16'sd23170;
      errors = 0;
    endfunction

    function void write_reg(hps_pkg::cfg_reg_e idx, logic [23:0] val);
      case (idx)
        hps_pkg::REG_SLOPE_GAIN: gain = val;
        hps_pkg::REG_SUN_SIN:    sin_q = val[15:0];
        hps_pkg::REG_SUN_COS:    cos_q = val[15:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] isqrt(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function logic [7:0] tint(logic [7:0] ch, logic [63:0] f);
      logic [63:0] v;
      v = ((64'd8192 + 64'd224 * ch) * f) >> 23;
      return (v > 255) ? 8'hff : v[7:0];
    endfunction

    function void note_pixel(hps_pkg::in_t px);
      longint d, s, root, c;
      logic [63:0] mag, q, absc, f;
      hps_pkg::out_t o;
      d = longint'(px.elev_upper_left) - longint'(px.elev_lower_right);
      mag = (d < 0) ? -d : d;
      q = (mag * gain) >> 5;
      if (q > 32768) q = 32768;
      s = (d < 0) ? -longint'(q) : longint'(q);
      root = isqrt((64'd1 << 30) - s * s);
      c = longint'(sin_q) * root - longint'(cos_q) * s;
      absc = (c < 0) ? -c : c;
      f = isqrt(absc);
      o.shaded_red = tint(px.base_red, f);
      o.shaded_green = tint(px.base_green, f);
      o.shaded_blue = tint(px.base_blue, f);
      pending.push_back(o);
    endfunction

    function void check_color(hps_pkg::out_t got);
      hps_pkg::out_t exp_c;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_c = pending.pop_front();
      if (got !== exp_c) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %h actual %h", exp_c, got);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_stall_o;
  hps_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 0;
  hps_pkg::out_t out_data_o;
  logic cfg_valid_i = 0;
  logic cfg_ready_o;
  logic [hps_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [hps_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  shade_board board = new();
  int idle_pct = 0;
  int stall_pct = 0;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  hillshade_pixel_shader_top dut (.*);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_color(out_data_o);
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_pixel(hps_pkg::in_t px);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_data_i <= px;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_pixel(px);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(hps_pkg::cfg_reg_e idx, logic [23:0] val);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.write_reg(idx, val);
  endtask

  function automatic hps_pkg::in_t rand_pixel(int small_d);
    hps_pkg::in_t px;
    px = hps_pkg::in_t'(72'({$urandom, $urandom, $urandom}));
    if (small_d != 0)
      px.elev_lower_right = px.elev_upper_left - ($urandom_range(4000) - 2000);
    return px;
  endfunction

  task automatic directed();
    logic signed [23:0] e[4] = '{24'sh7fffff, -24'sh800000, 24'sd0, 24'sd16};
    foreach (e[i]) foreach (e[j])
      send_pixel({e[i], e[j], 8'(i * 85), 8'hff, 8'h00});
    send_pixel({24'sd5, 24'sd5, 8'hff, 8'hff, 8'hff});
    send_pixel({24'sd0, 24'sd0, 8'h00, 8'h00, 8'h00});
  endtask

  initial begin
    int phase_pct[4][2];
    logic [23:0] cfgs[5][3];
    phase_pct = '{'{0, 0}, '{58, 0}, '{0, 58}, '{20, 20}};
    cfgs = '{
      '{24'd46478, 24'd23170, 24'd23170},
      '{24'hffffff, 24'h7fff, 24'h8000},
      '{24'd0, 24'h8000, 24'h7fff},
      '{24'd1, 24'h7fff, 24'h7fff},
      '{24'd3000, 24'h0000, 24'hc000}};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    directed();
    for (int k = 0; k < 5; k++) begin
      drain();
      write_reg(hps_pkg::REG_SLOPE_GAIN, cfgs[k][0]);
      write_reg(hps_pkg::REG_SUN_SIN, cfgs[k][1]);
      write_reg(hps_pkg::REG_SUN_COS, cfgs[k][2]);
      cfg_valid_i <= 0;
      for (int p = 0; p < 4; p++) begin
        idle_pct = phase_pct[p][0];
        stall_pct = phase_pct[p][1];
        for (int n = 0; n < 66; n++) send_pixel(rand_pixel($urandom_range(3) != 0));
      end
      idle_pct = 0;
      stall_pct = 0;
    end
    drain();
    if (board.errors == 0 && board.pending.size() == 0)
      $display("hillshade_pixel_shader_top_tb passed");
    else
      $display("hillshade_pixel_shader_top_tb failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("hillshade_pixel_shader_top_tb failed");
    $finish;
  end
endmodule

>>> sim.f
rtl/hps_pkg.sv
rtl/hps_cfg_regs.sv
rtl/hps_sqrt_pipe.sv
rtl/hillshade_pixel_shader_top.sv
test/hillshade_pixel_shader_top_tb.sv
